>>> rtl/efra_pkg.sv
`timescale 1ns / 1ps

package efra_pkg;

  // Default number of entries held by the queue.
  localparam int QUEUE_DEPTH_DEF = 32;

  // Width of the reported fill level.
  localparam int FILL_W = 6;

  // Event type and code constants.
  localparam logic [15:0] EV_KEY_TYPE      = 16'd1;
  localparam logic [15:0] MARK_TYPE        = 16'd0;
  localparam logic [15:0] MARK_CODE        = 16'd3;
  localparam logic [15:0] REMOVAL_TYPE_RST = 16'hFFFF;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_PASS   = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_POP    = 2'd2,
    REQ_SPARE  = 2'd3
  } req_code_t;

  // Result codes.
  typedef enum logic [2:0] {
    OUT_STORED         = 3'd0,
    OUT_DROPPED        = 3'd1,
    OUT_STORED_DISCARD = 3'd2,
    OUT_POPPED         = 3'd3,
    OUT_EMPTY          = 3'd4
  } outcome_t;

  // Configuration register indexes.
  localparam logic REG_REMOVAL_TYPE = 1'b0;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [15:0]        ev_type;
    logic [15:0]        ev_code;
    logic signed [31:0] ev_value;
  } req_t;

  typedef struct packed {
    logic [2:0]         outcome;
    logic [15:0]        out_type;
    logic [15:0]        out_code;
    logic signed [31:0] out_value;
    logic [5:0]         fill_level;
  } res_t;

  // One queue entry as stored.
  typedef struct packed {
    logic [15:0] ev_type;
    logic [15:0] ev_code;
    logic [31:0] ev_value;
  } entry_t;

endpackage

>>> rtl/event_fifo_reserve_admission.sv
`timescale 1ns / 1ps

// Channel      | Handshake                  | Payload
// -------------+----------------------------+---------------------------
// request in   | start, busy (busy is low)  | in_req  (req_t)
// result out   | out_valid (one-cycle strobe)| out_res (res_t)
// config       | APB: psel, penable, pwrite | paddr, pwdata, prdata
//
// Every request is accepted in the cycle it is offered, so busy is always low and
// the block sustains one transaction per clock cycle. The queue pointer and count
// update at the accepting edge, and the result appears on the following cycle,
// as the entry memory read port and the other result fields are registered.
// The synchronous active-low reset empties the queue and restores the removal
// event type; the entry memory itself is not cleared, as no entry is read before
// it is written. The receiver cannot stall, so each result is shown exactly once.
module event_fifo_reserve_admission
  import efra_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        start,
  output logic        busy,
  input  req_t        in_req,
  // Result channel.
  output logic        out_valid,
  output res_t        out_res,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic [CNT_W-1:0] DEPTH_C    = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] LIMIT_REL  = CNT_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] LIMIT_OTH  = CNT_W'(QUEUE_DEPTH - 2);
  localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_SUM  = SUM_W'(QUEUE_DEPTH);

  // Control state.
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      rem_type_r;
  logic             out_valid_r;
  logic [2:0]       outcome_r;
  logic [CNT_W-1:0] fill_r;

  // Entry memory and its read register.
  entry_t           mem [QUEUE_DEPTH];
  entry_t           rd_data_r;

  logic             accept;
  logic             wr_en;
  logic             rd_en;
  entry_t           wr_data;
  outcome_t         outcome_nxt;
  logic             drop_old;
  logic             is_release;
  logic             admit;
  logic [SUM_W-1:0] wsum;
  logic [SUM_W-1:0] wsum_wrap;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] rp_inc;
  logic             cfg_wr;
  logic [CNT_W+FILL_W-1:0] fill_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pready = 1'b1;

  // Configuration write and read-back. The register index is the word address.
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_REMOVAL_TYPE) ? {16'd0, rem_type_r} : 32'd0;

  // The append slot always lies at (oldest + count) modulo depth: a discard
  // before the append moves the pointer up and the count down by one each.
  assign wsum      = SUM_W'(rp_r) + SUM_W'(cnt_r);
  assign wsum_wrap = (wsum >= DEPTH_SUM) ? (wsum - DEPTH_SUM) : wsum;
  assign wr_addr   = wsum_wrap[PTR_W-1:0];
  assign rp_inc    = (rp_r == PTR_LAST) ? '0 : (rp_r + 1'b1);

  // A key release needs two free slots, anything else needs three, so a
  // release can still get in when ordinary events are already refused.
  assign is_release = (in_req.ev_type == EV_KEY_TYPE) && (in_req.ev_value == 32'sd0);
  assign admit      = is_release ? (cnt_r < LIMIT_REL) : (cnt_r < LIMIT_OTH);

  always_comb begin
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    drop_old    = 1'b0;
    wr_data     = '{ev_type: in_req.ev_type, ev_code: in_req.ev_code,
                    ev_value: in_req.ev_value};
    outcome_nxt = OUT_STORED;
    cnt_nxt     = cnt_r;
    rp_nxt      = rp_r;
    unique case (in_req.req_type) inside
      REQ_PASS: begin
        wr_en = 1'b1;
        if (admit) begin
          outcome_nxt = OUT_STORED;
        end else begin
          // Refused: the oldest entry gives way to a drop marker.
          outcome_nxt = OUT_DROPPED;
          drop_old    = (cnt_r != '0);
          wr_data     = '{ev_type: MARK_TYPE, ev_code: MARK_CODE, ev_value: 32'd0};
        end
      end
      REQ_REMOVE: begin
        wr_en   = 1'b1;
        wr_data = '{ev_type: rem_type_r, ev_code: 16'd0, ev_value: 32'd0};
        if (cnt_r == DEPTH_C) begin
          outcome_nxt = OUT_STORED_DISCARD;
          drop_old    = 1'b1;
        end else begin
          outcome_nxt = OUT_STORED;
        end
      end
      REQ_POP, REQ_SPARE: begin
        if (cnt_r != '0) begin
          rd_en       = 1'b1;
          outcome_nxt = OUT_POPPED;
          rp_nxt      = rp_inc;
          cnt_nxt     = cnt_r - 1'b1;
        end else begin
          outcome_nxt = OUT_EMPTY;
        end
      end
    endcase
    // Appends always fit: a discard or spare room precedes every write.
    if (wr_en) begin
      if (drop_old) begin
        rp_nxt = rp_inc;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r        <= '0;
      cnt_r       <= '0;
      rem_type_r  <= REMOVAL_TYPE_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        rp_r  <= rp_nxt;
        cnt_r <= cnt_nxt;
      end
      if (cfg_wr && (paddr[2] == REG_REMOVAL_TYPE)) begin
        rem_type_r <= pwdata[15:0];
      end
    end
  end

  // Result fields other than the popped data.
  always_ff @(posedge clk) begin
    if (accept) begin
      outcome_r <= outcome_nxt;
      fill_r    <= cnt_nxt;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && rd_en) begin
      rd_data_r <= mem[rp_r];
    end
  end

  assign fill_ext  = {{FILL_W{1'b0}}, fill_r};
  assign out_valid = out_valid_r;

  always_comb begin
    out_res            = '0;
    out_res.outcome    = outcome_r;
    out_res.fill_level = fill_ext[FILL_W-1:0];
    if (outcome_r == OUT_POPPED) begin
      out_res.out_type  = rd_data_r.ev_type;
      out_res.out_code  = rd_data_r.ev_code;
      out_res.out_value = rd_data_r.ev_value;
    end
  end

`ifndef ASSERT_OFF
  a_strobe_follows_accept : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("result strobe missing after an accepted request");

  a_no_spurious_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid_r)
    else $error("result strobe without an accepted request");

  a_count_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count exceeds queue depth");

  a_pop_needs_entry : assert property (@(posedge clk) disable iff (!rst_n)
    accept && (outcome_nxt == OUT_POPPED) |-> (cnt_r != '0))
    else $error("pop reported on an empty queue");

  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ((cnt_r == $past(cnt_r)) || (cnt_r == $past(cnt_r) + 1'b1)
                || (cnt_r == $past(cnt_r) - 1'b1)))
    else $error("entry count moved by more than one");
`endif

endmodule

>>> verif/efra_checker.sv
`timescale 1ns / 1ps

module efra_checker
  import efra_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  req_t        in_req,
  input  logic        out_valid,
  input  res_t        out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          results_owed
);

  localparam logic [2:0] REMOVAL_ADDR = {REG_REMOVAL_TYPE, 2'b00};

  // Shadow copy of the queue and of the removal type register.
  entry_t      slots [DEPTH];
  int unsigned head;
  int unsigned held;
  logic [15:0] removal_type;

  res_t owed_results [$];

  function automatic void discard_oldest();
    if (held > 0) begin
      head = (head + 1) % DEPTH;
      held--;
    end
  endfunction

  function automatic void push_entry(logic [15:0] t, logic [15:0] c, logic [31:0] v);
    int unsigned w;
    if (held >= DEPTH) return;
    w = (head + held) % DEPTH;
    slots[w].ev_type  = t;
    slots[w].ev_code  = c;
    slots[w].ev_value = v;
    held++;
  endfunction

  // Applies one request to the shadow queue and returns the result it causes.
  function automatic res_t admit_request(req_t r);
    res_t        o;
    int unsigned reserve;
    o = '0;
    case (req_code_t'(r.req_type))
      REQ_PASS: begin
        reserve = (r.ev_type == EV_KEY_TYPE && r.ev_value == 0) ? 1 : 2;
        if (held < DEPTH - reserve) begin
          push_entry(r.ev_type, r.ev_code, r.ev_value);
          o.outcome = OUT_STORED;
        end else begin
          discard_oldest();
          push_entry(MARK_TYPE, MARK_CODE, 32'd0);
          o.outcome = OUT_DROPPED;
        end
      end
      REQ_REMOVE: begin
        o.outcome = OUT_STORED;
        if (held >= DEPTH) begin
          discard_oldest();
          o.outcome = OUT_STORED_DISCARD;
        end
        push_entry(removal_type, 16'd0, 32'd0);
      end
      default: begin
        // The spare request code behaves as a pop.
        if (held > 0) begin
          o.out_type  = slots[head].ev_type;
          o.out_code  = slots[head].ev_code;
          o.out_value = slots[head].ev_value;
          discard_oldest();
          o.outcome = OUT_POPPED;
        end else begin
          o.outcome = OUT_EMPTY;
        end
      end
    endcase
    o.fill_level = FILL_W'(held);
    return o;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      head = 0;
      held = 0;
      removal_type = REMOVAL_TYPE_RST;
      owed_results.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REMOVAL_ADDR)
        removal_type = pwdata[15:0];

      if (out_valid) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result transaction: %p", out_res);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          if (out_res.outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, out_res.outcome);
            mismatches++;
          end
          if (out_res.out_type !== want.out_type) begin
            $error("out_type: expected %h, got %h", want.out_type, out_res.out_type);
            mismatches++;
          end
          if (out_res.out_code !== want.out_code) begin
            $error("out_code: expected %h, got %h", want.out_code, out_res.out_code);
            mismatches++;
          end
          if (out_res.out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d", want.out_value, out_res.out_value);
            mismatches++;
          end
          if (out_res.fill_level !== want.fill_level) begin
            $error("fill_level: expected %0d, got %0d", want.fill_level,
                   out_res.fill_level);
            mismatches++;
          end
        end
      end

      if (start && !busy)
        owed_results.push_back(admit_request(in_req));
    end
    results_owed = owed_results.size();
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the event queue with reserve-based admission.
// The checker beside the block predicts every result; this module only makes
// request transactions and configuration writes, then decides pass or fail.
module tb_top;
  import efra_pkg::*;

  localparam int         RANDOM_ITEMS = 1950;
  localparam int         PHASES       = 13;
  localparam logic [2:0] REMOVAL_ADDR = {REG_REMOVAL_TYPE, 2'b00};

  // Each random phase leans the request mix one way, so that the queue
  // is driven up against full, drained to empty, or held in between.
  typedef enum int {FILL_HEAVY, BALANCED, DRAIN_HEAVY} traffic_mix_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  req_t        in_req;
  logic        out_valid;
  res_t        out_res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          results_owed;
  bit          steady_phase;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  event_fifo_reserve_admission i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  efra_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req       (in_req),
    .out_valid    (out_valid),
    .out_res      (out_res),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  function automatic req_t make_req(logic [1:0] code, logic [15:0] t, logic [15:0] c,
                                    logic [31:0] v);
    req_t r;
    r.req_type = code;
    r.ev_type  = t;
    r.ev_code  = c;
    r.ev_value = v;
    return r;
  endfunction

  // Idle cycles before the next request. Most gaps are short, a few are long,
  // and some phases run back to back with no gaps at all.
  function automatic int idle_cycles();
    int roll;
    if (steady_phase) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // A random request under the given mix. Pass events favor key releases,
  // since only those are admitted one slot closer to full; the remaining
  // payloads are either random over the whole field or key and sync events.
  function automatic req_t random_req(traffic_mix_t mix);
    int          roll;
    int          kind;
    logic [1:0]  code;
    logic [15:0] t;
    logic [31:0] v;
    roll = $urandom_range(0, 99);
    case (mix)
      FILL_HEAVY:  code = roll < 40 ? REQ_PASS : roll < 70 ? REQ_REMOVE :
                          roll < 95 ? REQ_POP : REQ_SPARE;
      DRAIN_HEAVY: code = roll < 20 ? REQ_PASS : roll < 30 ? REQ_REMOVE :
                          roll < 95 ? REQ_POP : REQ_SPARE;
      default:     code = roll < 40 ? REQ_PASS : roll < 55 ? REQ_REMOVE :
                          roll < 95 ? REQ_POP : REQ_SPARE;
    endcase
    t = 16'($urandom());
    v = $urandom();
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      t = EV_KEY_TYPE;
      v = '0;
    end else if (kind < 45) begin
      t = EV_KEY_TYPE;
    end else if (kind < 55) begin
      t = MARK_TYPE;
      if ($urandom_range(0, 1) == 0) v = '0;
    end else if (kind < 60) begin
      v = '0;
    end
    return make_req(code, t, 16'($urandom()), v);
  endfunction

  // Offers one request transaction. It stays on the port until the block takes
  // it at a rising edge with busy low; all driving happens on falling edges.
  task automatic issue(input req_t r);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) begin
        // The payload wanders while start is low; the block must ignore it.
        in_req = {2'($urandom()), $urandom(), $urandom()};
        @(negedge clk);
      end
    end
    start  = 1'b1;
    in_req = r;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Lets every owed result drain, then gives the registered result stage a little
  // more time before anything that needs an idle block.
  task automatic settle();
    start = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_removal_type(input logic [15:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = REMOVAL_ADDR;
    // Upper bits carry noise; the register only keeps the low half.
    pwdata  = {16'($urandom()), value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  initial begin
    req_t        opening [$];
    logic [15:0] removal_value;
    traffic_mix_t mix;
    int          per_phase;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_req       = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    steady_phase = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Opening sequence, run with the removal type still at its reset value.
    // It pops and uses the spare code on an empty queue, stores a removal
    // notice below full, passes events with the field extremes, a key press,
    // a key release and a sync event, and then pops everything back out.
    opening.push_back(make_req(REQ_POP, 16'h0000, 16'h0000, 32'h0));
    opening.push_back(make_req(REQ_SPARE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    opening.push_back(make_req(REQ_REMOVE, 16'h1234, 16'h5678, 32'h9ABC_DEF0));
    opening.push_back(make_req(REQ_PASS, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF));
    opening.push_back(make_req(REQ_PASS, 16'h0000, 16'h0000, 32'h8000_0000));
    opening.push_back(make_req(REQ_PASS, EV_KEY_TYPE, 16'h001E, 32'h0));
    opening.push_back(make_req(REQ_PASS, EV_KEY_TYPE, 16'h001E, 32'h1));
    opening.push_back(make_req(REQ_PASS, EV_KEY_TYPE, 16'hAAAA, 32'hFFFF_FFFF));
    opening.push_back(make_req(REQ_PASS, MARK_TYPE, 16'h5555, 32'h0));
    opening.push_back(make_req(REQ_POP, 16'h0000, 16'h0000, 32'h0));
    opening.push_back(make_req(REQ_SPARE, 16'h0000, 16'h0000, 32'h0));
    repeat (5) opening.push_back(make_req(REQ_POP, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    opening.push_back(make_req(REQ_POP, 16'h0000, 16'h0000, 32'h0));
    foreach (opening[i]) issue(opening[i]);

    // Random phases. Each starts from an idle block with a new removal type:
    // both extremes first, then the key type, then random values. The mix
    // cycles through filling, balanced and draining traffic.
    per_phase = RANDOM_ITEMS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       removal_value = 16'h0000;
        1:       removal_value = 16'hFFFF;
        2:       removal_value = EV_KEY_TYPE;
        default: removal_value = 16'($urandom());
      endcase
      write_removal_type(removal_value);
      mix          = traffic_mix_t'(ph % 3);
      steady_phase = ($urandom_range(0, 3) == 0);
      repeat (per_phase) issue(random_req(mix));
    end

    settle();
    if (mismatches == 0 && results_owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Generous bound on the whole run; a healthy run ends far sooner.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
rtl/efra_pkg.sv
rtl/event_fifo_reserve_admission.sv
verif/efra_checker.sv
verif/tb_top.sv
